FILE: rtl/core/opra_pkg.sv
// ----------------------------------------------------------------------------
// opra_pkg: shared types and constants for the energy accounting block
// Widths, opcodes, row kinds, controller states and command structs.
// ----------------------------------------------------------------------------
package opra_pkg;

  localparam int unsigned NumCpus   = 4;
  localparam int unsigned NumPoints = 16;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned CpuW      = 2;
  localparam int unsigned PtW       = 4;
  localparam int unsigned CntW      = 5;
  localparam int unsigned DivW      = 64;
  localparam int unsigned DivCntW   = 7;

  localparam logic [31:0] RawDivReset = 32'd6000;
  localparam logic [CntW-1:0] PointsReset = 5'd16;
  localparam logic [6:0] PctScale = 7'd100;

  typedef enum logic [2:0] {
    OpLoad   = 3'd0,
    OpSample = 3'd1,
    OpCommit = 3'd2,
    OpClear  = 3'd3,
    OpReport = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    KindCpu   = 2'd0,
    KindPoint = 2'd1,
    KindTotal = 2'd2
  } row_kind_e;

  typedef enum logic {
    CfgPoints = 1'b0,
    CfgRawDiv = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StSearch,
    StCpuRow,
    StPtMul,
    StPtMulHi,
    StPtDivCost,
    StPtDivRaw,
    StPtDivPct,
    StPtRow,
    StTotRow,
    StClrWait
  } state_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [CpuW-1:0]  cpu_id;
    logic [63:0]      idle_us;
    logic [63:0]      wall_us;
    logic [63:0]      now_us;
    logic [31:0]      target_freq;
    logic [PtW-1:0]   point_index;
    logic [31:0]      point_freq;
    logic [31:0]      point_power;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  row_kind;
    logic [3:0]  row_index;
    logic [31:0] power_level;
    logic [63:0] active_time;
    logic [63:0] point_wall_time;
    logic [63:0] power_cost;
    logic [63:0] raw_power;
    logic [31:0] busy_percent;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    DivSelCost = 2'd0,
    DivSelRaw  = 2'd1,
    DivSelPct  = 2'd2
  } div_sel_e;

  typedef enum logic [1:0] {
    RowCpu   = 2'd0,
    RowPoint = 2'd1,
    RowTotal = 2'd2
  } row_sel_e;

  typedef struct packed {
    logic             latch_in;
    logic             do_load;
    logic             do_sample;
    logic             do_commit;
    logic             do_clear;
    logic             search_start;
    logic             search_step;
    logic             set_point;
    logic             mul_start;
    logic             div_start;
    div_sel_e         div_sel;
    logic             sum_clear;
    logic             build_row;
    row_sel_e         row_sel;
    logic [PtW-1:0]   idx;
  } ctl_t;

  typedef struct packed {
    in_item_t         item;
    logic [CntW-1:0]  used;
    logic             search_hit;
    logic             div_busy;
    logic             mul_done;
  } sts_t;

endpackage

FILE: rtl/core/opra_if.sv
// ----------------------------------------------------------------------------
// opra_if: valid/ready channel interfaces
// Input and output streams carry a packed payload; config carries an index and write data.
// ----------------------------------------------------------------------------
interface opra_in_if import opra_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface opra_out_if import opra_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface opra_cfg_if ();
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/core/opp_residency_power_accounting_top.sv
// ----------------------------------------------------------------------------
// opp_residency_power_accounting_top: per-cluster energy accounting
// Operating point tables, residency accumulators and report generation.
// ----------------------------------------------------------------------------
// Commit and clear also search the frequency table after the decode
//   (one table entry searched a cycle).
// Report: 4 cpu rows, then per point a multiply in low and high halves and
//   three serial divides, then the total row.
// Reset: all accumulators zero, points_in_use 16, divisor 6000; the
//   frequency and power tables hold no reset value until loaded.
module opp_residency_power_accounting_top import opra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  opra_in_if.sink    in_ch,
  opra_out_if.source out_ch,
  opra_cfg_if.sink   cfg_ch
);
  ctl_t ctl;
  sts_t sts;

  // config always taken; writes must come only while idle, not enforced by the block
  assign cfg_ch.ready = 1'b1;

  opra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  opra_datapath u_dp (
    .clk_i, .rst_ni,
    .in_data_i   (in_ch.data),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_idx_i   (cfg_ch.index),
    .cfg_wdata_i (cfg_ch.wdata),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .row_o       (out_ch.data)
  );
endmodule

FILE: rtl/core/opra_div.sv
// ----------------------------------------------------------------------------
// opra_div: radix-2 restoring divider
// 64-bit unsigned quotient, one bit per cycle; divide by zero yields zero.
// ----------------------------------------------------------------------------
module opra_div import opra_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  output logic            busy_o,
  output logic [DivW-1:0] quot_o
);
  logic [DivW-1:0]    q_q, q_d, d_q, d_d;
  logic [DivW:0]      r_q, r_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d, zero_q, zero_d;
  logic [DivW:0]      trial;

  always_comb begin
    q_d = q_q; d_d = d_q; r_d = r_q; cnt_d = cnt_q;
    busy_d = busy_q; zero_d = zero_q;
    trial = {r_q[DivW-1:0], q_q[DivW-1]};
    if (start_i) begin
      q_d = num_i; d_d = den_i; r_d = '0;
      cnt_d = DivCntW'(DivW); busy_d = 1'b1;
      zero_d = (den_i == '0);
    end else if (busy_q) begin
      // shift one dividend bit in, subtract when it fits
      if (trial >= {1'b0, d_q}) begin
        r_d = trial - {1'b0, d_q};
        q_d = {q_q[DivW-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; d_q <= d_d; r_q <= r_d; zero_q <= zero_d;
  end

  assign busy_o = busy_q;
  assign quot_o = zero_q ? '0 : q_q;
endmodule

FILE: rtl/core/opra_datapath.sv
// ----------------------------------------------------------------------------
// opra_datapath: accumulators, tables, product and row building
// Executes controller commands; reports item fields and unit status.
// ----------------------------------------------------------------------------
module opra_datapath import opra_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  ctl_t        ctl_i,
  output sts_t        sts_o,
  output out_item_t   row_o
);
  in_item_t          item_q;
  logic [CntW-1:0]   pts_q;
  logic [31:0]       rawdiv_q;
  logic [TimeW-1:0]  prev_idle_q [NumCpus];
  logic [TimeW-1:0]  prev_wall_q [NumCpus];
  logic [TimeW-1:0]  cpu_wall_q  [NumCpus];
  logic [TimeW-1:0]  pt_act_q    [NumPoints];
  logic [TimeW-1:0]  pt_wall_q   [NumPoints];
  logic [31:0]       freq_q      [NumPoints];
  logic [31:0]       pwr_q       [NumPoints];
  logic [TimeW-1:0]  elapsed_q, last_time_q;
  logic [PtW-1:0]    cur_q, hit_q;
  logic              hit_found_q;
  logic [63:0]       prod_q, pctp_q, cost_q, raw_q, pct_q, sum_q;
  logic              mul_done_q;
  logic [CntW-1:0]   used;
  logic [TimeW-1:0]  di, dw;
  logic [63:0]       div_num, div_den, quot;
  logic              div_busy, div_busy_q;
  logic [31:0]       mul_a;
  logic [63:0]       mul_p;
  out_item_t         row_q, row_d;

  always_comb begin
    if (pts_q == '0) used = CntW'(1);
    else if (pts_q > CntW'(NumPoints)) used = CntW'(NumPoints);
    else used = pts_q;
  end

  assign di = item_q.idle_us - prev_idle_q[item_q.cpu_id];
  assign dw = item_q.wall_us - prev_wall_q[item_q.cpu_id];

  // one 32x32 multiplier: low half of the busy time first, high half next cycle
  assign mul_a = mul_done_q ? pt_act_q[ctl_i.idx][63:32] : pt_act_q[ctl_i.idx][31:0];
  assign mul_p = {32'd0, mul_a} * {32'd0, pwr_q[ctl_i.idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_q <= PointsReset;
      rawdiv_q <= RawDivReset;
      elapsed_q <= '0; last_time_q <= '0; cur_q <= '0;
      for (int i = 0; i < NumCpus; i++) begin
        prev_idle_q[i] <= '0; prev_wall_q[i] <= '0; cpu_wall_q[i] <= '0;
      end
      for (int i = 0; i < NumPoints; i++) begin
        pt_act_q[i] <= '0; pt_wall_q[i] <= '0;
      end
      mul_done_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgPoints) pts_q <= cfg_wdata_i[CntW-1:0];
        else rawdiv_q <= cfg_wdata_i;
      end
      if (ctl_i.do_sample) begin
        prev_idle_q[item_q.cpu_id] <= item_q.idle_us;
        prev_wall_q[item_q.cpu_id] <= item_q.wall_us;
        if (prev_wall_q[item_q.cpu_id] != '0 && dw >= di) begin
          pt_act_q[cur_q]  <= pt_act_q[cur_q] + (dw - di);
          pt_wall_q[cur_q] <= pt_wall_q[cur_q] + dw;
          cpu_wall_q[item_q.cpu_id] <= cpu_wall_q[item_q.cpu_id] + dw;
        end
      end
      if (ctl_i.do_commit) begin
        elapsed_q   <= elapsed_q + (item_q.now_us - last_time_q);
        last_time_q <= item_q.now_us;
      end
      if (ctl_i.do_clear) begin
        elapsed_q <= '0;
        last_time_q <= item_q.now_us;
        for (int i = 0; i < NumCpus; i++) begin
          prev_idle_q[i] <= '0; prev_wall_q[i] <= '0; cpu_wall_q[i] <= '0;
        end
        for (int i = 0; i < NumPoints; i++) begin
          pt_act_q[i] <= '0; pt_wall_q[i] <= '0;
        end
      end
      if (ctl_i.set_point) cur_q <= hit_q;
      mul_done_q <= ctl_i.mul_start;
    end
  end

  always_comb begin
    row_d = '0;
    case (ctl_i.row_sel)
      RowCpu: begin
        row_d.row_kind = KindCpu;
        row_d.row_index = ctl_i.idx;
        row_d.active_time = cpu_wall_q[ctl_i.idx[CpuW-1:0]];
      end
      RowPoint: begin
        row_d.row_kind = KindPoint;
        row_d.row_index = ctl_i.idx;
        row_d.power_level = pwr_q[ctl_i.idx];
        row_d.active_time = pt_act_q[ctl_i.idx];
        row_d.point_wall_time = pt_wall_q[ctl_i.idx];
        row_d.power_cost = cost_q;
        row_d.raw_power = raw_q;
        row_d.busy_percent = pct_q[31:0];
      end
      default: begin
        row_d.row_kind = KindTotal;
        row_d.power_cost = sum_q;
        row_d.last = 1'b1;
      end
    endcase
  end

  // tables and item latch carry no reset
  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) item_q <= in_data_i;
    if (ctl_i.do_load) begin
      freq_q[item_q.point_index] <= item_q.point_freq;
      pwr_q[item_q.point_index]  <= item_q.point_power;
    end
    // search: one table entry a cycle, stop on first hit
    if (ctl_i.search_start) begin
      hit_q <= PtW'(used - 1'b1);
      hit_found_q <= 1'b0;
    end else if (ctl_i.search_step && !hit_found_q) begin
      if (freq_q[ctl_i.idx] >= item_q.target_freq) begin
        hit_q <= ctl_i.idx;
        hit_found_q <= 1'b1;
      end
    end
    if (ctl_i.mul_start) begin
      prod_q <= mul_p;
      pctp_q <= pt_act_q[ctl_i.idx] * 64'(PctScale);
    end else if (mul_done_q) begin
      prod_q <= prod_q + {mul_p[31:0], 32'd0};
    end
    div_busy_q <= div_busy;
    if (div_busy_q && !div_busy) begin
      case (ctl_i.div_sel)
        DivSelCost: cost_q <= quot;
        DivSelRaw:  raw_q  <= quot;
        default:    pct_q  <= quot;
      endcase
    end
    if (ctl_i.sum_clear) sum_q <= '0;
    else if (ctl_i.build_row && ctl_i.row_sel == RowPoint) sum_q <= sum_q + cost_q;
    if (ctl_i.build_row) row_q <= row_d;
  end

  always_comb begin
    case (ctl_i.div_sel)
      DivSelCost: begin div_num = prod_q; div_den = elapsed_q; end
      DivSelRaw:  begin div_num = prod_q; div_den = 64'(rawdiv_q); end
      default:    begin div_num = pctp_q; div_den = pt_wall_q[ctl_i.idx]; end
    endcase
  end

  opra_div u_div (
    .clk_i, .rst_ni,
    .start_i (ctl_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quot_o  (quot)
  );

  assign sts_o.item       = item_q;
  assign sts_o.used       = used;
  assign sts_o.search_hit = hit_found_q;
  assign sts_o.div_busy   = div_busy | div_busy_q;
  assign sts_o.mul_done   = mul_done_q;
  assign row_o = row_q;
endmodule

FILE: rtl/core/opra_ctrl.sv
// ----------------------------------------------------------------------------
// opra_ctrl: operation sequencer
// Accepts one beat, steps the datapath, hands report rows to the output.
// ----------------------------------------------------------------------------
module opra_ctrl import opra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  sts_t  sts_i,
  output ctl_t  ctl_o
);
  state_e         st_q, st_d;
  logic [PtW:0]   idx_q, idx_d;
  logic           ov_q, ov_d;
  logic           dwait_q, dwait_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; idx_q <= '0; ov_q <= 1'b0; dwait_q <= 1'b0;
    end else begin
      st_q <= st_d; idx_q <= idx_d; ov_q <= ov_d; dwait_q <= dwait_d;
    end
  end

  always_comb begin
    st_d = st_q; idx_d = idx_q; ov_d = ov_q; dwait_d = dwait_q;
    ctl_o = '0;
    ctl_o.idx = idx_q[PtW-1:0];
    ctl_o.div_sel = DivSelCost;
    ctl_o.row_sel = RowCpu;
    in_ready_o = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          ctl_o.latch_in = 1'b1;
          st_d = StClrWait;
        end
      end
      StClrWait: begin
        // decode the latched beat
        idx_d = '0;
        st_d = StIdle;
        case (sts_i.item.opcode)
          OpLoad:   ctl_o.do_load = 1'b1;
          OpSample: ctl_o.do_sample = 1'b1;
          OpCommit: begin
            ctl_o.do_commit = 1'b1; ctl_o.search_start = 1'b1; st_d = StSearch;
          end
          OpClear: begin
            ctl_o.do_clear = 1'b1; ctl_o.search_start = 1'b1; st_d = StSearch;
          end
          OpReport: begin
            ctl_o.sum_clear = 1'b1; st_d = StCpuRow;
          end
          default: st_d = StIdle;
        endcase
      end
      StSearch: begin
        if (idx_q < sts_i.used && !sts_i.search_hit) begin
          ctl_o.search_step = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          ctl_o.set_point = 1'b1;
          st_d = StIdle;
        end
      end
      StCpuRow: begin
        if (!ov_d) begin
          ctl_o.build_row = 1'b1; ctl_o.row_sel = RowCpu;
          ov_d = 1'b1;
          if (idx_q == (PtW+1)'(NumCpus - 1)) begin
            idx_d = '0; st_d = StPtMul;
          end else idx_d = idx_q + 1'b1;
        end
      end
      StPtMul: begin
        ctl_o.mul_start = 1'b1;
        st_d = StPtMulHi;
        dwait_d = 1'b0;
      end
      StPtMulHi: begin
        // high half of the product folds in this cycle
        if (sts_i.mul_done) st_d = StPtDivCost;
      end
      StPtDivCost, StPtDivRaw, StPtDivPct: begin
        ctl_o.div_sel = (st_q == StPtDivCost) ? DivSelCost :
                        (st_q == StPtDivRaw) ? DivSelRaw : DivSelPct;
        if (!dwait_q) begin
          ctl_o.div_start = 1'b1; dwait_d = 1'b1;
        end else if (!sts_i.div_busy) begin
          dwait_d = 1'b0;
          st_d = (st_q == StPtDivCost) ? StPtDivRaw :
                 (st_q == StPtDivRaw) ? StPtDivPct : StPtRow;
        end
      end
      StPtRow: begin
        if (!ov_d) begin
          ctl_o.build_row = 1'b1; ctl_o.row_sel = RowPoint;
          ov_d = 1'b1;
          if (idx_q + 1'b1 >= sts_i.used) st_d = StTotRow;
          else begin
            idx_d = idx_q + 1'b1; st_d = StPtMul;
          end
        end
      end
      StTotRow: begin
        if (!ov_d) begin
          ctl_o.build_row = 1'b1; ctl_o.row_sel = RowTotal;
          ov_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;
endmodule

FILE: rtl/core/opra_checker.sv
// ----------------------------------------------------------------------------
// opra_checker: port-level checks
// Watches the top level's channels over time.
// ----------------------------------------------------------------------------
module opra_checker import opra_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic [1:0] out_kind
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  // no input taken while a result waits
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken during output");
  // last flag only on total rows
  a_last_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_last |-> out_kind == KindTotal) else $error("bad last");
  // accepted beat blocks the next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("back to back accept");
endmodule

bind opp_residency_power_accounting_top opra_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid (in_ch.valid), .in_ready (in_ch.ready),
  .out_valid (out_ch.valid), .out_ready (out_ch.ready),
  .out_last (out_ch.data.last), .out_kind (out_ch.data.row_kind)
);

FILE: verif/opp_residency_power_accounting_top_test.sv
// ----------------------------------------------------------------------------
// opp_residency_power_accounting_top_test: energy accounting regression
// Loads the point tables, then drives directed and random sample, commit,
// clear and report beats under random idling on both sides. Every report row
// is checked against an in-bench model of the accumulators and cost math.
// ----------------------------------------------------------------------------
module opp_residency_power_accounting_top_test;
  import opra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DirRows = 28;
  localparam logic [2:0]  OpUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  opra_in_if  in_ch ();
  opra_out_if out_ch ();
  opra_cfg_if cfg_ch ();

  opp_residency_power_accounting_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk_i = ~clk_i;

  // Shadow state of the accounting block.
  logic [63:0] sh_prev_idle [NumCpus];
  logic [63:0] sh_prev_wall [NumCpus];
  logic [63:0] sh_cpu_wall  [NumCpus];
  logic [63:0] sh_pt_active [NumPoints];
  logic [63:0] sh_pt_wall   [NumPoints];
  logic [31:0] sh_freq      [NumPoints];
  logic [31:0] sh_power     [NumPoints];
  logic [63:0] sh_elapsed;
  logic [63:0] sh_last_time;
  logic [3:0]  sh_cur_pt;
  logic [4:0]  sh_points;
  logic [31:0] sh_raw_div;

  // Report rows still owed by the block, oldest first.
  out_item_t rows_due [$];

  // Stimulus-side counters so most samples form a plausible history.
  logic [63:0] gen_idle [NumCpus];
  logic [63:0] gen_wall [NumCpus];
  logic [63:0] gen_now;

  int  errors = 0;
  bit  calm = 1'b0;  // no idling on either side while set

  function automatic int unsigned points_used();
    if (sh_points == 5'd0) return 1;
    if (sh_points > NumPoints) return NumPoints;
    return 32'(sh_points);
  endfunction

  function automatic logic [3:0] search_point(logic [31:0] f);
    int unsigned n;
    n = points_used();
    for (int unsigned i = 0; i < n; i++)
      if (sh_freq[i] >= f) return i[3:0];
    return 4'(n - 1);
  endfunction

  function automatic logic [63:0] div0(logic [63:0] a, logic [63:0] b);
    return (b == 64'd0) ? 64'd0 : a / b;
  endfunction

  // Advance the shadow state by one accepted beat; queue any report rows.
  function automatic void account_beat(in_item_t it);
    logic [63:0] di, dw, prod, cost, sum;
    out_item_t   r;
    bit          first;
    case (it.opcode)
      OpLoad: begin
        sh_freq[it.point_index]  = it.point_freq;
        sh_power[it.point_index] = it.point_power;
      end
      OpSample: begin
        di = it.idle_us - sh_prev_idle[it.cpu_id];
        dw = it.wall_us - sh_prev_wall[it.cpu_id];
        first = (sh_prev_wall[it.cpu_id] == 64'd0);
        sh_prev_idle[it.cpu_id] = it.idle_us;
        sh_prev_wall[it.cpu_id] = it.wall_us;
        if (!first && dw >= di) begin
          sh_pt_active[sh_cur_pt] += dw - di;
          sh_pt_wall[sh_cur_pt]   += dw;
          sh_cpu_wall[it.cpu_id]  += dw;
        end
      end
      OpCommit: begin
        sh_elapsed  += it.now_us - sh_last_time;
        sh_last_time = it.now_us;
        sh_cur_pt    = search_point(it.target_freq);
      end
      OpClear: begin
        for (int c = 0; c < NumCpus; c++) begin
          sh_prev_idle[c] = '0;
          sh_prev_wall[c] = '0;
          sh_cpu_wall[c]  = '0;
        end
        for (int p = 0; p < NumPoints; p++) begin
          sh_pt_active[p] = '0;
          sh_pt_wall[p]   = '0;
        end
        sh_elapsed   = '0;
        sh_last_time = it.now_us;
        sh_cur_pt    = search_point(it.target_freq);
      end
      OpReport: begin
        sum = '0;
        for (int c = 0; c < NumCpus; c++) begin
          r = '0;
          r.row_kind    = KindCpu;
          r.row_index   = 4'(c);
          r.active_time = sh_cpu_wall[c];
          rows_due.push_back(r);
        end
        for (int unsigned p = 0; p < points_used(); p++) begin
          prod = sh_pt_active[p] * {32'd0, sh_power[p]};
          cost = div0(prod, sh_elapsed);
          sum += cost;
          r = '0;
          r.row_kind        = KindPoint;
          r.row_index       = 4'(p);
          r.power_level     = sh_power[p];
          r.active_time     = sh_pt_active[p];
          r.point_wall_time = sh_pt_wall[p];
          r.power_cost      = cost;
          r.raw_power       = div0(prod, {32'd0, sh_raw_div});
          r.busy_percent    = 32'(div0(sh_pt_active[p] * 64'd100, sh_pt_wall[p]));
          rows_due.push_back(r);
        end
        r = '0;
        r.row_kind   = KindTotal;
        r.power_cost = sum;
        r.last       = 1'b1;
        rows_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Hold the beat until the block takes it; valid stays high for a follow-on.
  task automatic send_beat(in_item_t it);
    while (!calm && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    account_beat(it);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == CfgPoints) sh_points = val[4:0];
    else sh_raw_div = val;
  endtask

  // Drop valid and let the block go quiet; commits may still be searching.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic in_item_t random_beat();
    in_item_t    it;
    int unsigned r, s, c;
    logic [63:0] dw, di;
    it.opcode      = 3'($urandom_range(7));
    it.cpu_id      = 2'($urandom_range(3));
    it.idle_us     = rand64();
    it.wall_us     = rand64();
    it.now_us      = rand64();
    it.target_freq = $urandom();
    it.point_index = 4'($urandom_range(15));
    it.point_freq  = $urandom();
    it.point_power = $urandom();
    r = $urandom_range(99);
    if (r < 65 && r >= 45) begin
      it.opcode = OpCommit;
      if ($urandom_range(9) != 0) gen_now += 64'($urandom_range(50000));
      else gen_now = it.now_us;
      it.now_us = gen_now;
      s = $urandom_range(3);
      if (s == 0) it.target_freq = sh_freq[$urandom_range(15)];
      else if (s == 1) it.target_freq = '0;
    end else if (r < 75 && r >= 65) begin
      it.opcode = OpLoad;
    end else if (r < 80 && r >= 75) begin
      it.opcode = OpClear;
      gen_now += 64'($urandom_range(1000));
      it.now_us = gen_now;
    end else if (r < 88 && r >= 80) begin
      it.opcode = OpReport;
    end else if (r < 93 && r >= 88) begin
      it.opcode = 3'($urandom_range(5, 7));
    end else begin
      it.opcode = OpSample;
      c = 32'(it.cpu_id);
      s = $urandom_range(9);
      if (s == 0) begin
        // noise: arbitrary counters
      end else if (s == 1) begin
        // idle advances further than wall
        dw = 64'($urandom_range(1000));
        di = dw + 64'($urandom_range(1, 1000));
        it.wall_us = gen_wall[c] + dw;
        it.idle_us = gen_idle[c] + di;
      end else begin
        dw = 64'($urandom_range(1, 100000));
        di = 64'($urandom_range(0, 32'(dw)));
        it.wall_us = gen_wall[c] + dw;
        it.idle_us = gen_idle[c] + di;
      end
      gen_wall[c] = it.wall_us;
      gen_idle[c] = it.idle_us;
    end
    return it;
  endfunction

  // Compare each delivered row with the oldest owed row; refresh ready.
  always @(posedge clk_i) begin
    out_item_t want, got;
    bit        bad;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (rows_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected row: %p", got);
      end else begin
        want = rows_due.pop_front();
        bad = (got.row_kind !== want.row_kind) || (got.row_index !== want.row_index) ||
              (got.power_level !== want.power_level) ||
              (got.active_time !== want.active_time) ||
              (got.point_wall_time !== want.point_wall_time) ||
              (got.power_cost !== want.power_cost) || (got.raw_power !== want.raw_power) ||
              (got.busy_percent !== want.busy_percent) || (got.last !== want.last);
        if (bad) begin
          errors++;
          if (errors <= 10) $display("row mismatch: exp %p act %p", want, got);
        end
      end
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 23);
  end

  initial begin
    in_item_t dir_beat [DirRows];
    bit       dir_zero [DirRows];
    in_item_t it;
    int       zero_at;

    rst_ni        = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CfgPoints;
    cfg_ch.wdata <= '0;

    for (int c = 0; c < NumCpus; c++) begin
      sh_prev_idle[c] = '0; sh_prev_wall[c] = '0; sh_cpu_wall[c] = '0;
      gen_idle[c] = '0; gen_wall[c] = 64'd1000;
    end
    for (int p = 0; p < NumPoints; p++) begin
      sh_pt_active[p] = '0; sh_pt_wall[p] = '0; sh_freq[p] = '0; sh_power[p] = '0;
    end
    sh_elapsed = '0; sh_last_time = '0; sh_cur_pt = '0;
    sh_points = PointsReset; sh_raw_div = RawDivReset;
    gen_now = 64'd10000;

    // Directed table: load every point first so no unwritten entry is read.
    for (int i = 0; i < DirRows; i++) begin
      dir_beat[i] = '0;
      dir_zero[i] = 1'b0;
    end
    for (int p = 0; p < NumPoints; p++) begin
      dir_beat[p].opcode      = OpLoad;
      dir_beat[p].point_index = 4'(p);
      dir_beat[p].point_freq  = 32'((p + 1) * 150000);
      dir_beat[p].point_power = 32'(p * 40);
    end
    dir_beat[15].point_freq  = 32'hFFFF_FFFF;
    dir_beat[15].point_power = 32'hFFFF_FFFF;
    // report with nothing accumulated: total cost must be zero
    dir_beat[16].opcode = OpReport;  dir_zero[16] = 1'b1;
    // first sample only records; second charges busy time
    dir_beat[17] = '{opcode: OpSample, cpu_id: 2'd0, idle_us: 64'd10, wall_us: 64'd100,
                     default: '0};
    dir_beat[18] = '{opcode: OpSample, cpu_id: 2'd0, idle_us: 64'd30, wall_us: 64'd400,
                     default: '0};
    dir_beat[19] = '{opcode: OpSample, cpu_id: 2'd3, idle_us: 64'd5, wall_us: 64'd50,
                     default: '0};
    // idle jumps past wall
    dir_beat[20] = '{opcode: OpSample, cpu_id: 2'd3, idle_us: 64'd900, wall_us: 64'd60,
                     default: '0};
    dir_beat[21] = '{opcode: OpCommit, now_us: 64'd1000, target_freq: 32'hFFFF_FFFF,
                     default: '0};
    dir_beat[22] = '{opcode: OpCommit, now_us: 64'd5000, target_freq: 32'd0, default: '0};
    dir_beat[23] = '{opcode: OpSample, cpu_id: 2'd0, idle_us: 64'd0, wall_us: '1,
                     default: '0};
    dir_beat[24] = '{opcode: OpUnused, cpu_id: 2'd3, idle_us: '1, wall_us: '1, now_us: '1,
                     target_freq: '1, point_index: 4'hF, point_freq: '1, point_power: '1};
    dir_beat[25].opcode = OpReport;
    dir_beat[26] = '{opcode: OpClear, now_us: '1, target_freq: 32'd160000, default: '0};
    dir_beat[27].opcode = OpReport;  dir_zero[27] = 1'b1;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      send_beat(dir_beat[i]);
      if (dir_zero[i]) begin
        zero_at = rows_due.size() - 1;
        rows_due[zero_at].power_cost = 64'd0;
      end
    end
    gen_now = 64'd20000;

    // Each phase: settle, program the registers, then a random burst.
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      case (ph)
        1: begin write_reg(CfgPoints, 32'd0);  write_reg(CfgRawDiv, 32'd0); end
        2: begin write_reg(CfgPoints, 32'hFFFF_FFFF); write_reg(CfgRawDiv, '1); end
        3: begin
          write_reg(CfgPoints, 32'($urandom_range(1, 16)));
          write_reg(CfgRawDiv, $urandom());
        end
        4: begin write_reg(CfgPoints, 32'd16); write_reg(CfgRawDiv, 32'd1); end
        default: write_reg(CfgRawDiv, RawDivReset);
      endcase
      calm = (ph == 2);
      for (int n = 0; n < 26; n++) begin
        it = random_beat();
        send_beat(it);
      end
      calm = 1'b0;
    end

    drain();
    if (errors == 0 && rows_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #36_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
